[hdl/swp_pkg.sv]
// Shared types, constants and a helper function of the swipe path generator.
`default_nettype none

package swp_pkg;

    localparam int REF_X_W = 11;
    localparam int REF_Y_W = 10;
    localparam int DEV_W   = 12;
    localparam int STEP_W  = 8;
    localparam int DLY_W   = 8;
    localparam int ID_W    = 8;
    localparam int OUT_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [DEV_W-1:0]  RST_WIDTH  = 12'd1280;
    localparam logic [DEV_W-1:0]  RST_HEIGHT = 12'd720;
    localparam logic [STEP_W-1:0] RST_STEP   = 8'd10;
    localparam logic [DLY_W-1:0]  RST_DELAY  = 8'd8;

    // c*width/1280 = ((c*width) >> 8) / 5, c*height/720 = ((c*height) >> 4) / 45
    localparam int PX_W = REF_X_W + DEV_W;
    localparam int PY_W = REF_Y_W + DEV_W;
    localparam int X_SHIFT = 8;
    localparam int Y_SHIFT = 4;
    localparam int TX_W = PX_W - X_SHIFT;
    localparam int TY_W = PY_W - Y_SHIFT;
    localparam int X_RECIP_W = 16;
    localparam int Y_RECIP_W = 19;
    localparam logic [X_RECIP_W-1:0] X_RECIP = 16'd52429;   // ceil(2^18 / 5)
    localparam logic [Y_RECIP_W-1:0] Y_RECIP = 19'd372828;  // ceil(2^24 / 45)
    localparam int X_RSHIFT = 18;
    localparam int Y_RSHIFT = 24;
    localparam int Q_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_STEP   = 2'd2,
        REG_DELAY  = 2'd3
    } t_reg_idx;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    typedef enum logic {
        KIND_DOWN = 1'b0,
        KIND_MOVE = 1'b1
    } t_kind;

    // one restoring step of a remainder by the move step
    function automatic logic [STEP_W-1:0] f_mod_bit(input logic [STEP_W-1:0] rem,
                                                    input logic bit_in,
                                                    input logic [STEP_W-1:0] step);
        logic [STEP_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, step}) begin
            t = t - {1'b0, step};
        end
        return t[STEP_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/swipe_path_generator.sv]
// Top level of the swipe path generator: scaling pipeline, remainder pipeline, line walker.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_stall       | command, start/stop x y, finger id, down flag
//  output   | o_out_valid / i_out_stall     | pos x y, touch kind, delay, pointer id, last
//  config   | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_stall is low. Registered path: input register, scale
// multiply, reciprocal multiply, remainder stages (4 bits each), walker/result register.
// A stalled result holds the whole pipeline. After a move_step write the input stalls
// while the pipeline drains and a serial rebuild recomputes the walker's step remainder.
// Reset is synchronous; it clears valids, walker state and config to defaults.
`default_nettype none

module swipe_path_generator #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_command,
    input  wire logic [swp_pkg::REF_X_W-1:0]       i_start_x,
    input  wire logic [swp_pkg::REF_Y_W-1:0]       i_start_y,
    input  wire logic [swp_pkg::REF_X_W-1:0]       i_stop_x,
    input  wire logic [swp_pkg::REF_Y_W-1:0]       i_stop_y,
    input  wire logic [swp_pkg::ID_W-1:0]          i_finger_id,
    input  wire logic                              i_need_touch_down,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [swp_pkg::OUT_W-1:0]              o_pos_x,
    output logic [swp_pkg::OUT_W-1:0]              o_pos_y,
    output logic                                   o_touch_kind,
    output logic [swp_pkg::DLY_W-1:0]              o_delay,
    output logic [swp_pkg::ID_W-1:0]               o_pointer_id,
    output logic                                   o_last,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [swp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [swp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW    = COORD_BITS;
    localparam int ERR_W = CW + 2;
    localparam int NIB   = 4;
    localparam int NST   = (CW + NIB - 1) / NIB;
    localparam int PW    = NST * NIB;
    localparam int QW    = swp_pkg::Q_W;
    localparam int EXT_W = (CW > QW) ? CW : QW;
    localparam logic [EXT_W-1:0] CMAX = EXT_W'((1 << CW) - 1);
    localparam int CNT_W = $clog2(CW + 1);
    localparam int OW    = swp_pkg::OUT_W;
    localparam int SW    = swp_pkg::STEP_W;
    localparam int DW    = swp_pkg::DLY_W;
    localparam int IW    = swp_pkg::ID_W;
    localparam int VW    = swp_pkg::DEV_W;
    localparam int XW    = swp_pkg::REF_X_W;
    localparam int YW    = swp_pkg::REF_Y_W;
    localparam int PXW   = swp_pkg::PX_W;
    localparam int PYW   = swp_pkg::PY_W;
    localparam int TXW   = swp_pkg::TX_W;
    localparam int TYW   = swp_pkg::TY_W;
    localparam int MXW   = TXW + swp_pkg::X_RECIP_W;
    localparam int MYW   = TYW + swp_pkg::Y_RECIP_W;

    typedef struct packed {
        logic          cmd;
        logic          ntd;
        logic [IW-1:0] fid;
        logic [SW-1:0] step;
        logic [DW-1:0] dly;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] adx;
        logic [CW-1:0] ady;
        logic          dxn;
        logic          dyn;
        logic [SW-1:0] rx;
        logic [SW-1:0] ry;
    } t_dst;

    function automatic logic [CW-1:0] f_sat(input logic [QW-1:0] q);
        logic [EXT_W-1:0] qe;
        qe = EXT_W'(q);
        return (qe > CMAX) ? {CW{1'b1}} : CW'(q);
    endfunction

    // configuration
    logic [VW-1:0] r_dev_w, r_dev_h;
    logic [SW-1:0] r_move_step;
    logic [DW-1:0] r_event_delay;
    logic          cfg_we;

    // pipeline control
    logic en, in_acc, pipe_busy;

    // stage A
    logic          r_a_v, r_a_cmd, r_a_ntd;
    logic [XW-1:0] r_a_sx, r_a_ex;
    logic [YW-1:0] r_a_sy, r_a_ey;
    logic [IW-1:0] r_a_fid;
    logic [VW-1:0] r_a_w, r_a_h;
    logic [SW-1:0] r_a_step;
    logic [DW-1:0] r_a_dly;

    // stage B
    logic           r_b_v, r_b_cmd, r_b_ntd;
    logic [PXW-1:0] r_b_pxs, r_b_pxe;
    logic [PYW-1:0] r_b_pys, r_b_pye;
    logic [IW-1:0]  r_b_fid;
    logic [SW-1:0]  r_b_step;
    logic [DW-1:0]  r_b_dly;

    // stage C
    logic           r_c_v, r_c_cmd, r_c_ntd;
    logic [CW-1:0]  r_c_sx, r_c_sy, r_c_ex, r_c_ey;
    logic [IW-1:0]  r_c_fid;
    logic [SW-1:0]  r_c_step;
    logic [DW-1:0]  r_c_dly;
    logic [TXW-1:0] c_txs, c_txe;
    logic [TYW-1:0] c_tys, c_tye;
    logic [MXW-1:0] c_mxs, c_mxe;
    logic [MYW-1:0] c_mys, c_mye;

    // remainder stages
    t_dst d_in;
    t_dst r_d  [NST];
    logic r_dv [NST];
    t_dst f;
    logic f_v;

    // walker state
    logic                 r_busy, n_busy;
    logic [CW-1:0]        r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic signed [ERR_W-1:0] r_err, n_err, e1, e2;
    logic [CW-1:0]        r_left, n_left;
    logic                 r_maj_x, n_maj_x, r_dxn, n_dxn, r_dyn, n_dyn;
    logic [CW-1:0]        r_dmaj, n_dmaj, r_dmin, n_dmin;
    logic [IW-1:0]        r_finger, n_finger;
    logic [SW-1:0]        r_res, n_res, res_nxt;
    logic                 minor, res_dn, step_ok, fin, s_maj_x;
    logic [CW-1:0]        nx, ny;

    // result
    logic                 e_v, e_last;
    swp_pkg::t_kind       e_kind;
    logic [CW-1:0]        e_x, e_y;
    logic [DW-1:0]        e_dly;
    logic [IW-1:0]        e_pid;
    logic                 r_out_v;
    logic [OW-1:0]        r_o_x, r_o_y;
    swp_pkg::t_kind       r_o_kind;
    logic [DW-1:0]        r_o_dly;
    logic [IW-1:0]        r_o_pid;
    logic                 r_o_last;

    // remainder rebuild after a move_step write
    logic             r_rc_pend, r_rc_run, rc_start, rc_done;
    logic [CNT_W-1:0] r_rc_cnt;
    logic [CW-1:0]    r_rc_val;
    logic [SW-1:0]    r_rc_rem, rc_rem_nxt;

    assign en         = !(r_out_v && i_out_stall);
    assign o_in_stall = !en || r_rc_pend || r_rc_run;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we     = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_w       <= swp_pkg::RST_WIDTH;
            r_dev_h       <= swp_pkg::RST_HEIGHT;
            r_move_step   <= swp_pkg::RST_STEP;
            r_event_delay <= swp_pkg::RST_DELAY;
        end else if (cfg_we) begin
            unique case (swp_pkg::t_reg_idx'(i_cfg_index))
                swp_pkg::REG_WIDTH:  r_dev_w       <= i_cfg_data[VW-1:0];
                swp_pkg::REG_HEIGHT: r_dev_h       <= i_cfg_data[VW-1:0];
                swp_pkg::REG_STEP:   r_move_step   <= i_cfg_data[SW-1:0];
                swp_pkg::REG_DELAY:  r_event_delay <= i_cfg_data[DW-1:0];
            endcase
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (en) begin
            r_a_v <= in_acc;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    // stage A: input beat plus config snapshot
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_cmd  <= i_command;
            r_a_ntd  <= i_need_touch_down;
            r_a_sx   <= i_start_x;
            r_a_sy   <= i_start_y;
            r_a_ex   <= i_stop_x;
            r_a_ey   <= i_stop_y;
            r_a_fid  <= i_finger_id;
            r_a_w    <= r_dev_w;
            r_a_h    <= r_dev_h;
            r_a_step <= r_move_step;
            r_a_dly  <= r_event_delay;
        end
    end

    // stage B: coordinate times device size
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_cmd  <= r_a_cmd;
            r_b_ntd  <= r_a_ntd;
            r_b_fid  <= r_a_fid;
            r_b_step <= r_a_step;
            r_b_dly  <= r_a_dly;
            r_b_pxs  <= r_a_sx * r_a_w;
            r_b_pxe  <= r_a_ex * r_a_w;
            r_b_pys  <= r_a_sy * r_a_h;
            r_b_pye  <= r_a_ey * r_a_h;
        end
    end

    // stage C: exact divide by reciprocal, saturate
    assign c_txs = r_b_pxs[PXW-1:swp_pkg::X_SHIFT];
    assign c_txe = r_b_pxe[PXW-1:swp_pkg::X_SHIFT];
    assign c_tys = r_b_pys[PYW-1:swp_pkg::Y_SHIFT];
    assign c_tye = r_b_pye[PYW-1:swp_pkg::Y_SHIFT];
    assign c_mxs = c_txs * swp_pkg::X_RECIP;
    assign c_mxe = c_txe * swp_pkg::X_RECIP;
    assign c_mys = c_tys * swp_pkg::Y_RECIP;
    assign c_mye = c_tye * swp_pkg::Y_RECIP;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_cmd  <= r_b_cmd;
            r_c_ntd  <= r_b_ntd;
            r_c_fid  <= r_b_fid;
            r_c_step <= r_b_step;
            r_c_dly  <= r_b_dly;
            r_c_sx   <= f_sat(c_mxs[swp_pkg::X_RSHIFT +: QW]);
            r_c_ex   <= f_sat(c_mxe[swp_pkg::X_RSHIFT +: QW]);
            r_c_sy   <= f_sat(c_mys[swp_pkg::Y_RSHIFT +: QW]);
            r_c_ey   <= f_sat(c_mye[swp_pkg::Y_RSHIFT +: QW]);
        end
    end

    // deltas and directions
    always_comb begin
        d_in      = '0;
        d_in.cmd  = r_c_cmd;
        d_in.ntd  = r_c_ntd;
        d_in.fid  = r_c_fid;
        d_in.step = r_c_step;
        d_in.dly  = r_c_dly;
        d_in.sx   = r_c_sx;
        d_in.sy   = r_c_sy;
        d_in.dxn  = r_c_ex < r_c_sx;
        d_in.dyn  = r_c_ey < r_c_sy;
        d_in.adx  = d_in.dxn ? r_c_sx - r_c_ex : r_c_ex - r_c_sx;
        d_in.ady  = d_in.dyn ? r_c_sy - r_c_ey : r_c_ey - r_c_sy;
    end

    // start point remainders by move_step, four bits per stage
    for (genvar k = 0; k < NST; k++) begin : g_mod
        t_dst          src, n_q;
        logic          src_v;
        logic [PW-1:0] xp, yp;

        if (k == 0) begin : g_first
            assign src   = d_in;
            assign src_v = r_c_v;
        end else begin : g_next
            assign src   = r_d[k-1];
            assign src_v = r_dv[k-1];
        end

        always_comb begin
            n_q = src;
            xp  = PW'(src.sx);
            yp  = PW'(src.sy);
            for (int j = 0; j < NIB; j++) begin
                n_q.rx = swp_pkg::f_mod_bit(n_q.rx, xp[PW-1-NIB*k-j], src.step);
                n_q.ry = swp_pkg::f_mod_bit(n_q.ry, yp[PW-1-NIB*k-j], src.step);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (en) begin
                r_dv[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d[k] <= n_q;
            end
        end
    end

    assign f   = r_d[NST-1];
    assign f_v = r_dv[NST-1];

    always_comb begin
        pipe_busy = r_a_v || r_b_v || r_c_v;
        for (int k = 0; k < NST; k++) begin
            pipe_busy = pipe_busy || r_dv[k];
        end
    end

    // line walker
    always_comb begin
        n_busy   = r_busy;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_err    = r_err;
        n_left   = r_left;
        n_maj_x  = r_maj_x;
        n_dxn    = r_dxn;
        n_dyn    = r_dyn;
        n_dmaj   = r_dmaj;
        n_dmin   = r_dmin;
        n_finger = r_finger;
        n_res    = r_res;
        e_v      = 1'b0;
        e_x      = r_cur_x;
        e_y      = r_cur_y;
        e_kind   = swp_pkg::KIND_MOVE;
        e_last   = 1'b0;
        e_dly    = f.dly;
        e_pid    = r_finger;

        s_maj_x = f.adx > f.ady;
        step_ok = f.step != '0;
        e1      = r_err - $signed({1'b0, r_dmin, 1'b0});
        minor   = e1 <= 0;
        e2      = minor ? e1 + $signed({1'b0, r_dmaj, 1'b0}) : e1;
        nx      = r_dxn ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        ny      = r_dyn ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        res_dn  = r_maj_x ? r_dxn : r_dyn;
        if (res_dn) begin
            res_nxt = (r_res == '0) ? f.step - 1'b1 : r_res - 1'b1;
        end else begin
            res_nxt = (r_res == f.step - 1'b1) ? '0 : r_res + 1'b1;
        end
        fin = r_left == CW'(1);

        if (f_v && en) begin
            if (f.cmd == swp_pkg::CMD_START) begin
                n_busy   = 1'b1;
                n_dxn    = f.dxn;
                n_dyn    = f.dyn;
                n_maj_x  = s_maj_x;
                n_dmaj   = s_maj_x ? f.adx : f.ady;
                n_dmin   = s_maj_x ? f.ady : f.adx;
                n_err    = $signed({2'b00, n_dmaj});
                n_left   = n_dmaj;
                n_cur_x  = f.sx;
                n_cur_y  = f.sy;
                n_finger = f.fid;
                n_res    = s_maj_x ? f.rx : f.ry;
                e_v      = f.ntd;
                e_x      = f.sx;
                e_y      = f.sy;
                e_kind   = swp_pkg::KIND_DOWN;
                e_pid    = f.fid;
            end else if (r_busy) begin
                if (r_left == '0) begin
                    n_busy = 1'b0;
                    e_v    = !(step_ok && r_res == '0);
                    e_last = 1'b1;
                end else begin
                    n_err = e2;
                    if (r_maj_x || minor) begin
                        n_cur_x = nx;
                    end
                    if (!r_maj_x || minor) begin
                        n_cur_y = ny;
                    end
                    n_left = r_left - 1'b1;
                    n_res  = res_nxt;
                    if (fin) begin
                        n_busy = 1'b0;
                    end
                    e_v    = fin || (step_ok && res_nxt == '0);
                    e_last = fin;
                    e_x    = n_cur_x;
                    e_y    = n_cur_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_err    <= '0;
            r_left   <= '0;
            r_maj_x  <= 1'b0;
            r_dxn    <= 1'b0;
            r_dyn    <= 1'b0;
            r_dmaj   <= '0;
            r_dmin   <= '0;
            r_finger <= '0;
            r_res    <= '0;
        end else begin
            r_busy   <= n_busy;
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_err    <= n_err;
            r_left   <= n_left;
            r_maj_x  <= n_maj_x;
            r_dxn    <= n_dxn;
            r_dyn    <= n_dyn;
            r_dmaj   <= n_dmaj;
            r_dmin   <= n_dmin;
            r_finger <= n_finger;
            r_res    <= rc_done ? rc_rem_nxt : n_res;
        end
    end

    // remainder rebuild: serial restoring remainder of the major coordinate
    assign rc_start   = r_rc_pend && !r_rc_run && !pipe_busy;
    assign rc_rem_nxt = swp_pkg::f_mod_bit(r_rc_rem, r_rc_val[CW-1], r_move_step);
    assign rc_done    = r_rc_run && (r_rc_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc_pend <= 1'b0;
            r_rc_run  <= 1'b0;
            r_rc_cnt  <= '0;
        end else begin
            if (cfg_we && swp_pkg::t_reg_idx'(i_cfg_index) == swp_pkg::REG_STEP) begin
                r_rc_pend <= 1'b1;
            end else if (rc_start) begin
                r_rc_pend <= 1'b0;
            end
            if (rc_start) begin
                r_rc_run <= 1'b1;
                r_rc_cnt <= CNT_W'(CW);
            end else if (r_rc_run) begin
                r_rc_cnt <= r_rc_cnt - 1'b1;
                if (rc_done) begin
                    r_rc_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rc_start) begin
            r_rc_val <= r_maj_x ? r_cur_x : r_cur_y;
            r_rc_rem <= '0;
        end else if (r_rc_run) begin
            r_rc_val <= {r_rc_val[CW-2:0], 1'b0};
            r_rc_rem <= rc_rem_nxt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && e_v) begin
            r_o_x    <= OW'(e_x);
            r_o_y    <= OW'(e_y);
            r_o_kind <= e_kind;
            r_o_dly  <= e_dly;
            r_o_pid  <= e_pid;
            r_o_last <= e_last;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_pos_x      = r_o_x;
    assign o_pos_y      = r_o_y;
    assign o_touch_kind = r_o_kind;
    assign o_delay      = r_o_dly;
    assign o_pointer_id = r_o_pid;
    assign o_last       = r_o_last;

endmodule

`default_nettype wire

[tb/swipe_path_generator_tb.sv]
// Self-checking testbench for the swipe path generator: directed and random swipes.
`timescale 1ns / 100ps

module swipe_path_generator_tb;

    localparam int XW  = swp_pkg::REF_X_W;
    localparam int YW  = swp_pkg::REF_Y_W;
    localparam int IDW = swp_pkg::ID_W;
    localparam int OW  = swp_pkg::OUT_W;
    localparam int VW  = swp_pkg::DEV_W;
    localparam int SW  = swp_pkg::STEP_W;
    localparam int DW  = swp_pkg::DLY_W;
    localparam int CIW = swp_pkg::CFG_IDX_W;
    localparam int CDW = swp_pkg::CFG_DATA_W;

    localparam int DRAIN_CYCLES   = 30;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REF_X_MAX      = 1279;
    localparam int REF_Y_MAX      = 719;

    typedef struct packed {
        swp_pkg::t_cmd  cmd;
        logic [XW-1:0]  start_x;
        logic [YW-1:0]  start_y;
        logic [XW-1:0]  stop_x;
        logic [YW-1:0]  stop_y;
        logic [IDW-1:0] finger_id;
        logic           need_down;
    } t_swipe_cmd;

    typedef struct packed {
        logic [OW-1:0]  pos_x;
        logic [OW-1:0]  pos_y;
        swp_pkg::t_kind kind;
        logic [DW-1:0]  delay;
        logic [IDW-1:0] pointer_id;
        logic           last;
    } t_touch_event;

    class t_swipe_tracker;
        logic [VW-1:0] dev_width  = swp_pkg::RST_WIDTH;
        logic [VW-1:0] dev_height = swp_pkg::RST_HEIGHT;
        logic [SW-1:0] move_step  = swp_pkg::RST_STEP;
        logic [DW-1:0] ev_delay   = swp_pkg::RST_DELAY;

        bit             busy;
        logic [OW-1:0]  cur_x, cur_y;
        int             err_acc;
        int             steps_left;
        bit             major_x, x_neg, y_neg;
        int             d_major, d_minor;
        logic [IDW-1:0] finger;

        t_touch_event pending_events[$];
        int           mismatch_count;

        function void write_reg(swp_pkg::t_reg_idx idx, logic [CDW-1:0] data);
            case (idx)
                swp_pkg::REG_WIDTH:  dev_width  = data[VW-1:0];
                swp_pkg::REG_HEIGHT: dev_height = data[VW-1:0];
                swp_pkg::REG_STEP:   move_step  = data[SW-1:0];
                swp_pkg::REG_DELAY:  ev_delay   = data[DW-1:0];
                default: ;
            endcase
        endfunction

        function logic [OW-1:0] scale(int unsigned c, int unsigned size, int unsigned span);
            int unsigned v;
            v = c * size / span;
            return (v > 4095) ? '1 : v[OW-1:0];
        endfunction

        function bit on_multiple(logic [OW-1:0] m);
            if (move_step == 0) begin
                return 1'b0;
            end
            return (m % move_step) == 0;
        endfunction

        function void emit(swp_pkg::t_kind kind, bit last);
            t_touch_event e;
            e.pos_x      = cur_x;
            e.pos_y      = cur_y;
            e.kind       = kind;
            e.delay      = ev_delay;
            e.pointer_id = finger;
            e.last       = last;
            pending_events = {pending_events, e};
        endfunction

        function void take_command(t_swipe_cmd c);
            logic [OW-1:0] sx, sy, ex, ey, m;
            int adx, ady;
            bit minor_step, final_px;
            if (c.cmd == swp_pkg::CMD_START) begin
                sx = scale(32'(c.start_x), 32'(dev_width), 1280);
                sy = scale(32'(c.start_y), 32'(dev_height), 720);
                ex = scale(32'(c.stop_x), 32'(dev_width), 1280);
                ey = scale(32'(c.stop_y), 32'(dev_height), 720);
                x_neg = ex < sx;
                y_neg = ey < sy;
                adx = x_neg ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
                ady = y_neg ? int'(sy) - int'(ey) : int'(ey) - int'(sy);
                major_x = adx > ady;
                d_major = major_x ? adx : ady;
                d_minor = major_x ? ady : adx;
                err_acc = d_major;
                steps_left = d_major;
                cur_x = sx;
                cur_y = sy;
                finger = c.finger_id;
                busy = 1'b1;
                if (c.need_down) begin
                    emit(swp_pkg::KIND_DOWN, 1'b0);
                end
                return;
            end
            if (!busy) begin
                return;
            end
            if (steps_left == 0) begin
                // zero-length path ends here
                busy = 1'b0;
                m = major_x ? cur_x : cur_y;
                if (!on_multiple(m)) begin
                    emit(swp_pkg::KIND_MOVE, 1'b1);
                end
                return;
            end
            err_acc -= 2 * d_minor;
            minor_step = err_acc <= 0;
            if (minor_step) begin
                err_acc += 2 * d_major;
            end
            if (major_x || minor_step) begin
                cur_x = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
            end
            if (!major_x || minor_step) begin
                cur_y = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
            end
            steps_left--;
            final_px = steps_left == 0;
            if (final_px) begin
                busy = 1'b0;
            end
            m = major_x ? cur_x : cur_y;
            if (final_px || on_multiple(m)) begin
                emit(swp_pkg::KIND_MOVE, final_px);
            end
        endfunction

        function void check_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            end
        endfunction

        function void match_event(t_touch_event got);
            t_touch_event exp;
            if (pending_events.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected event, expected none, actual x=%0d y=%0d kind=%0d",
                         $time, got.pos_x, got.pos_y, got.kind);
                return;
            end
            exp = pending_events.pop_front();
            check_field("pos_x", 32'(exp.pos_x), 32'(got.pos_x));
            check_field("pos_y", 32'(exp.pos_y), 32'(got.pos_y));
            check_field("touch_kind", 32'(exp.kind), 32'(got.kind));
            check_field("delay", 32'(exp.delay), 32'(got.delay));
            check_field("pointer_id", 32'(exp.pointer_id), 32'(got.pointer_id));
            check_field("last", 32'(exp.last), 32'(got.last));
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n           = 1'b0;
    logic           i_in_valid        = 1'b0;
    logic           o_in_stall;
    logic           i_command         = swp_pkg::CMD_START;
    logic [XW-1:0]  i_start_x         = '0;
    logic [YW-1:0]  i_start_y         = '0;
    logic [XW-1:0]  i_stop_x          = '0;
    logic [YW-1:0]  i_stop_y          = '0;
    logic [IDW-1:0] i_finger_id       = '0;
    logic           i_need_touch_down = 1'b0;
    logic           o_out_valid;
    logic           i_out_stall       = 1'b0;
    logic [OW-1:0]  o_pos_x;
    logic [OW-1:0]  o_pos_y;
    logic           o_touch_kind;
    logic [DW-1:0]  o_delay;
    logic [IDW-1:0] o_pointer_id;
    logic           o_last;
    logic           i_cfg_valid       = 1'b0;
    logic           o_cfg_ready;
    logic [CIW-1:0] i_cfg_index       = swp_pkg::REG_WIDTH;
    logic [CDW-1:0] i_cfg_data        = '0;

    t_swipe_tracker tracker = new;
    bit             calm;
    int             items_sent;
    int             quiet_cycles;
    t_touch_event   seen_event;

    swipe_path_generator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_start_x         (i_start_x),
        .i_start_y         (i_start_y),
        .i_stop_x          (i_stop_x),
        .i_stop_y          (i_stop_y),
        .i_finger_id       (i_finger_id),
        .i_need_touch_down (i_need_touch_down),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_pos_x           (o_pos_x),
        .o_pos_y           (o_pos_y),
        .o_touch_kind      (o_touch_kind),
        .o_delay           (o_delay),
        .o_pointer_id      (o_pointer_id),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    assign seen_event = '{o_pos_x, o_pos_y, swp_pkg::t_kind'(o_touch_kind), o_delay,
                          o_pointer_id, o_last};

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.match_event(seen_event);
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 27);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_swipe_cmd rand_cmd(swp_pkg::t_cmd cmd);
        t_swipe_cmd c;
        c.cmd       = cmd;
        c.start_x   = XW'($urandom_range(REF_X_MAX));
        c.start_y   = YW'($urandom_range(REF_Y_MAX));
        c.stop_x    = XW'($urandom_range(REF_X_MAX));
        c.stop_y    = YW'($urandom_range(REF_Y_MAX));
        c.finger_id = IDW'($urandom_range(255));
        c.need_down = 1'($urandom_range(1));
        return c;
    endfunction

    function automatic t_swipe_cmd make_start(int sx, int sy, int ex, int ey,
                                              logic [IDW-1:0] id, logic down);
        t_swipe_cmd c;
        c = '{swp_pkg::CMD_START, XW'(sx), YW'(sy), XW'(ex), YW'(ey), id, down};
        return c;
    endfunction

    function automatic int near(int base, int reach, int top);
        int v;
        v = base + int'($urandom_range(2 * reach)) - reach;
        return (v < 0) ? 0 : (v > top) ? top : v;
    endfunction

    // one input beat; returns at the falling edge after acceptance
    task automatic send_cmd(t_swipe_cmd c);
        while (!calm && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_command         <= c.cmd;
        i_start_x         <= c.start_x;
        i_start_y         <= c.start_y;
        i_stop_x          <= c.stop_x;
        i_stop_y          <= c.stop_y;
        i_finger_id       <= c.finger_id;
        i_need_touch_down <= c.need_down;
        do @(posedge i_clk); while (o_in_stall);
        if (c.cmd == swp_pkg::CMD_START || tracker.busy) begin
            items_sent++;
        end
        tracker.take_command(c);
        @(negedge i_clk);
    endtask

    task automatic run_swipe(t_swipe_cmd s, int max_steps);
        int n;
        n = 0;
        send_cmd(s);
        while (tracker.busy && n < max_steps) begin
            send_cmd(rand_cmd(swp_pkg::CMD_STEP));
            n++;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.pending_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_config(logic [VW-1:0] w, logic [VW-1:0] h,
                                logic [SW-1:0] s, logic [DW-1:0] d);
        swp_pkg::t_reg_idx regs [4];
        logic [CDW-1:0]    vals [4];
        regs = '{swp_pkg::REG_WIDTH, swp_pkg::REG_HEIGHT, swp_pkg::REG_STEP,
                 swp_pkg::REG_DELAY};
        vals = '{w, h, CDW'(s), CDW'(d)};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            tracker.write_reg(regs[i], vals[i]);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int quota);
        t_swipe_cmd s;
        int pick, reach, stop_at;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            s = rand_cmd(swp_pkg::CMD_START);
            if (pick < 5) begin
                send_cmd(rand_cmd(swp_pkg::CMD_STEP));
            end else if (pick < 8) begin
                wait_drained();
            end else if (pick < 18) begin
                // long path, usually cut short by the next start
                run_swipe(s, int'($urandom_range(60)));
            end else begin
                reach = ($urandom_range(3) == 0) ? 40 : 8;
                s.stop_x = XW'(near(int'(s.start_x), reach, REF_X_MAX));
                s.stop_y = YW'(near(int'(s.start_y), reach, REF_Y_MAX));
                run_swipe(s, ($urandom_range(9) == 0) ? int'($urandom_range(20)) : 1 << 13);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_cmd(rand_cmd(swp_pkg::CMD_STEP));
        run_swipe(make_start(0, 0, 0, 0, 8'h00, 1'b1), 10);
        run_swipe(make_start(5, 5, 5, 5, 8'hFF, 1'b0), 10);
        run_swipe(make_start(1279, 719, 1270, 712, 8'hA5, 1'b1), 3);
        run_swipe(make_start(1024, 512, 1027, 520, 8'h01, 1'b1), 10);
        run_swipe(make_start(100, 100, 104, 96, 8'h80, 1'b0), 10);
        run_swipe(make_start(0, 719, 1279, 0, 8'h5A, 1'b1), 2);
        random_phase(150);

        wait_drained();
        apply_config(12'd4095, 12'd4095, 8'd255, 8'd255);
        random_phase(150);

        wait_drained();
        apply_config(12'd1, 12'd1, 8'd1, 8'd0);
        random_phase(100);

        wait_drained();
        calm = 1'b1;
        apply_config(12'd1280, 12'd720, 8'd1, 8'd8);
        random_phase(200);
        calm = 1'b0;

        wait_drained();
        apply_config(12'd640, 12'd360, 8'd3, 8'd17);
        random_phase(150);

        repeat (2) begin
            wait_drained();
            apply_config(VW'($urandom_range(4095, 1)), VW'($urandom_range(4095, 1)),
                         SW'($urandom_range(255, 1)), DW'($urandom_range(255)));
            random_phase(130);
        end

        wait_drained();
        if (tracker.mismatch_count == 0 && tracker.pending_events.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
